/* src/mpc_pkg.sv */
`default_nettype none

package mpc_pkg;

  localparam int CODE_W = 13;
  localparam int WIDTH_W = 13;
  localparam int HEIGHT_W = 16;
  localparam int PALETTE_W = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CODE_W-1:0] CODE_MAX = '1;

  localparam logic [CFG_INDEX_W-1:0] CFG_CODING_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_COUNT = 2'd3;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] sample;
    logic              frame_start;
  } mpc_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] coded;
    logic              row_end;
    logic              frame_end;
    logic              range_error;
  } mpc_out_t;

  // Where the pixel sits in the frame; selects the prediction rule.
  typedef struct packed {
    logic first_pixel;
    logic top_row;
    logic left_col;
  } mpc_pos_t;

endpackage

`default_nettype wire

/* src/mpc_datapath.sv */
`default_nettype none

module mpc_datapath import mpc_pkg::*; #(
  parameter int INDEX_BITS = 12
) (
  input  wire logic                  mode,
  input  wire logic [PALETTE_W-1:0]  palette_count,
  input  wire logic [CODE_W-1:0]     sample,
  input  wire mpc_pos_t              pos,
  input  wire logic [INDEX_BITS-1:0] west,
  input  wire logic [INDEX_BITS-1:0] north,
  input  wire logic [INDEX_BITS-1:0] northwest,
  output logic      [INDEX_BITS-1:0] pixel,
  output logic      [CODE_W-1:0]     coded,
  output logic                       range_error
);

  localparam int SW = ((INDEX_BITS > CODE_W) ? INDEX_BITS : CODE_W) + 2;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;
  localparam logic [INDEX_BITS:0] BOUND_MAX = {1'b1, {INDEX_BITS{1'b0}}};

  logic [INDEX_BITS-1:0] lo, hi, med, pred, enc_pixel;
  logic [INDEX_BITS:0]   med_sum, bound;
  logic signed [SW-1:0]  enc_r, dec_r;

  always_comb begin
    lo = (west < north) ? west : north;
    hi = (west < north) ? north : west;
    med_sum = (INDEX_BITS+1)'(west) + (INDEX_BITS+1)'(north) - (INDEX_BITS+1)'(northwest);
    priority if (northwest >= hi) begin
      med = lo;
    end else if (northwest <= lo) begin
      med = hi;
    end else begin
      med = INDEX_BITS'(med_sum);
    end

    priority if (pos.first_pixel) begin
      pred = '0;
    end else if (pos.top_row) begin
      pred = west;
    end else if (pos.left_col) begin
      pred = north;
    end else begin
      pred = med;
    end
  end

  always_comb begin
    enc_pixel = (32'(sample) > 32'(IDX_MAX)) ? IDX_MAX : INDEX_BITS'(sample);
    enc_r = $signed(SW'(enc_pixel)) - $signed(SW'(pred)) + $signed(SW'(palette_count));

    priority if (palette_count == '0) begin
      bound = (INDEX_BITS+1)'(1);
    end else if (32'(palette_count) > 32'(BOUND_MAX)) begin
      bound = BOUND_MAX;
    end else begin
      bound = (INDEX_BITS+1)'(palette_count);
    end
    dec_r = $signed(SW'(sample)) - $signed(SW'(palette_count)) + $signed(SW'(pred));

    range_error = 1'b0;
    if (mode == MODE_ENCODE) begin
      pixel = enc_pixel;
      priority if (enc_r < 0) begin
        coded = '0;
      end else if (enc_r > $signed(SW'(CODE_MAX))) begin
        coded = CODE_MAX;
      end else begin
        coded = CODE_W'(enc_r);
      end
    end else begin
      priority if (dec_r < 0) begin
        pixel = '0;
        range_error = 1'b1;
      end else if (dec_r >= $signed(SW'(bound))) begin
        pixel = INDEX_BITS'(bound - (INDEX_BITS+1)'(1));
        range_error = 1'b1;
      end else begin
        pixel = INDEX_BITS'(dec_r);
      end
      coded = CODE_W'(pixel);
    end
  end

endmodule

`default_nettype wire

/* src/med_predictive_coder.sv */
// MED (median edge detector) predictive coder over palette indices, raster order.
// Input channel in_valid/in_ready/in_data carries one pixel per transaction:
// a palette index in encode mode, a biased residual in decode mode, and
// frame_start to restart at row 0, column 0. Output channel
// out_valid/out_ready/out_data returns exactly one result per input.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 mode,
// 1 width, 2 height, 3 palette size); write only while the coder is idle.
// A pixel accepted into the compute stage reaches out_data through the output
// register at commit. Throughput: one pixel per cycle while the receiver does
// not stall. The north neighbor comes from a one-row line buffer read at acceptance
// and written back at commit; a read of the entry written in that same cycle is
// forwarded; the west value is a register closed through the predictor and adder.
// Reset clears counters, west/northwest values, valids and loads the default
// configuration; the line buffer needs no clearing pass.
// When the receiver stalls, the output register holds its result and one
// more pixel is still accepted into the compute stage; then in_ready drops.
`default_nettype none

module med_predictive_coder import mpc_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int INDEX_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire mpc_in_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output mpc_out_t                    out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                  coding_mode;
  logic [WIDTH_W-1:0]    frame_width;
  logic [HEIGHT_W-1:0]   frame_height;
  logic [PALETTE_W-1:0]  palette_count;

  logic [AW-1:0]         column_count, column_count_next;
  logic [HEIGHT_W-1:0]   row_count, row_count_next;
  logic [INDEX_BITS-1:0] west_value, northwest_value;

  logic [INDEX_BITS-1:0] line_mem [MAX_WIDTH];
  logic [INDEX_BITS-1:0] mem_q;

  logic                  s1_valid;
  logic [CODE_W-1:0]     s1_sample;
  mpc_pos_t              s1_pos;
  logic                  s1_row_end, s1_frame_end;
  logic [AW-1:0]         s1_addr;
  logic                  s1_fwd;
  logic [INDEX_BITS-1:0] s1_fwd_data;

  logic                  accept, commit;
  logic [AW-1:0]         col, col_last;
  logic [HEIGHT_W-1:0]   row, row_last;
  logic                  row_end, frame_end;
  mpc_pos_t              pos;

  logic [INDEX_BITS-1:0] north, pixel;
  logic [CODE_W-1:0]     coded;
  logic                  range_error;

  // Compute stage retires whenever the output register is free or draining.
  assign commit   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || commit;
  assign accept   = in_valid && in_ready;

  always_comb begin
    priority if (frame_width == '0) begin
      col_last = '0;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      col_last = AW'(MAX_WIDTH - 1);
    end else begin
      col_last = AW'(frame_width - WIDTH_W'(1));
    end
    row_last = (frame_height == '0) ? '0 : frame_height - HEIGHT_W'(1);

    col = in_data.frame_start ? '0 : column_count;
    row = in_data.frame_start ? '0 : row_count;
    row_end   = col >= col_last;
    frame_end = row_end && (row >= row_last);

    pos.first_pixel = (col == '0) && (row == '0);
    pos.top_row     = (row == '0);
    pos.left_col    = (col == '0);

    column_count_next = row_end ? '0 : col + AW'(1);
    priority if (frame_end) begin
      row_count_next = '0;
    end else if (row_end) begin
      row_count_next = row + HEIGHT_W'(1);
    end else begin
      row_count_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode   <= MODE_ENCODE;
      frame_width   <= WIDTH_W'(512);
      frame_height  <= HEIGHT_W'(512);
      palette_count <= PALETTE_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODING_MODE:   coding_mode   <= cfg_data[0];
        CFG_FRAME_WIDTH:   frame_width   <= cfg_data[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[HEIGHT_W-1:0];
        CFG_PALETTE_COUNT: palette_count <= cfg_data[PALETTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Line buffer: read at acceptance, write back at commit.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= line_mem[col];
    end
    if (commit) begin
      line_mem[s1_addr] <= pixel;
    end
  end

  assign north = s1_fwd ? s1_fwd_data : mem_q;

  mpc_datapath #(
    .INDEX_BITS(INDEX_BITS)
  ) u_datapath (
    .mode          (coding_mode),
    .palette_count (palette_count),
    .sample        (s1_sample),
    .pos           (s1_pos),
    .west          (west_value),
    .north         (north),
    .northwest     (northwest_value),
    .pixel         (pixel),
    .coded         (coded),
    .range_error   (range_error)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      west_value      <= '0;
      northwest_value <= '0;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        s1_valid     <= 1'b1;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end

      if (commit) begin
        west_value      <= pixel;
        northwest_value <= north;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample    <= in_data.sample;
      s1_pos       <= pos;
      s1_row_end   <= row_end;
      s1_frame_end <= frame_end;
      s1_addr      <= col;
      // Bypass the entry being written back in this same cycle.
      s1_fwd       <= commit && (col == s1_addr);
      s1_fwd_data  <= pixel;
    end
    if (commit) begin
      out_data.coded       <= coded;
      out_data.row_end     <= s1_row_end;
      out_data.frame_end   <= s1_frame_end;
      out_data.range_error <= range_error;
    end
  end

endmodule

`default_nettype wire
